@@ hdl/dltq_pkg.sv @@
// Shared types and constants for the delta-list timer queue.
// No dependencies; used by delta_list_timer_queue_unit.
package dltq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int MAX_RESULTS     = 32;

	localparam int DELAY_W = 16;
	localparam int TAG_W   = 8;
	localparam int KIND_W  = 2;
	localparam int ENTRY_W = DELAY_W + TAG_W;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd3;

	typedef struct packed {
		logic               opcode;
		logic [DELAY_W-1:0] delay;
		logic [TAG_W-1:0]   event_tag;
	} req_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  expired_tag;
		logic              last;
	} rsp_item_t;

endpackage

@@ hdl/dltq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dltq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/delta_list_timer_queue_unit.sv @@
// Delta-list timer queue, top level.
// Depends on dltq_pkg and dltq_ram.
//
// Holds up to QUEUE_DEPTH pending events in time order, each entry storing its
// delay relative to the entry in front of it, in one RAM used as a ring
// (a head pointer marks the first entry, so expiry never moves data). An insert
// transaction walks the list one entry per cycle with one read in flight, then
// shifts the later entries up one place at one entry per cycle; when the new
// entry lands in front of an existing one it patches the delta of the entry
// behind the new one, and it then writes the new entry. The pace is set by
// the single read and single write port of the RAM. A full queue rejects an
// insert. A tick transaction decrements or expires the head and returns one
// result per expired event (at most 32 expiries per tick, later due entries
// wait for the next tick). The RAM needs no clearing pass: only entries below
// the fill count are ever read. One request is handled at a time; results
// leave through an output register, so the block returns to idle while the
// last result still waits to be taken.
module delta_list_timer_queue_unit #(
	parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  dltq_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dltq_pkg::rsp_item_t rsp_item
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(dltq_pkg::MAX_RESULTS + 1);
	localparam int DW = dltq_pkg::DELAY_W;
	localparam int TW = dltq_pkg::TAG_W;
	localparam int EW = dltq_pkg::ENTRY_W;

	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] HEAD_MAX = AW'(QUEUE_DEPTH - 1);
	localparam logic [NW-1:0] N_LIMIT = NW'(dltq_pkg::MAX_RESULTS - 1);

	// FSM codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WALK  = 4'd1;
	localparam logic [3:0] ST_SHIFT = 4'd2;
	localparam logic [3:0] ST_FIX   = 4'd3;
	localparam logic [3:0] ST_PUT   = 4'd4;
	localparam logic [3:0] ST_ONE   = 4'd5;
	localparam logic [3:0] ST_TFRST = 4'd6;
	localparam logic [3:0] ST_TNEXT = 4'd7;
	localparam logic [3:0] ST_TLAST = 4'd8;

	// Map a list position onto a RAM address: head plus offset, wrapped once.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
	                                       input logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, idx};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[AW-1:0];
	endfunction

	// Control state
	logic [3:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] head_q, head_d;
	logic [NW-1:0] n_q, n_d;
	logic          chk_s1, chk_d;
	logic          wpend_s1, wpend_d;

	// Working registers of the current transaction
	logic [DW-1:0] rem_q, rem_d;
	logic [TW-1:0] new_tag_q, new_tag_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [DW-1:0] split_q, split_d;
	logic [TW-1:0] split_tag_q, split_tag_d;
	logic [CW-1:0] walk_q, walk_d;
	logic [CW-1:0] chk_idx_s1, chk_idx_d;
	logic [CW-1:0] shift_src_q, shift_src_d;
	logic [CW-1:0] wdst_s1, wdst_d;
	logic [TW-1:0] pend_tag_q, pend_tag_d;
	logic [dltq_pkg::KIND_W-1:0] kind_q, kind_d;

	// RAM port
	logic          ram_rd_en, ram_wr_en;
	logic [AW-1:0] ram_rd_addr, ram_wr_addr;
	logic [EW-1:0] ram_wr_data, ram_rd_data;
	logic [DW-1:0] rd_delta;
	logic [TW-1:0] rd_tag;

	// Output register
	logic                rsp_valid_q;
	dltq_pkg::rsp_item_t rsp_item_q, rsp_d;
	logic                rsp_load, out_free;

	logic          walk_done, more;
	logic [AW-1:0] head_inc;

	dltq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_delta  = ram_rd_data[EW-1 -: DW];
	assign rd_tag    = ram_rd_data[TW-1:0];
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign head_inc  = (head_q == HEAD_MAX) ? '0 : head_q + AW'(1);
	// another head may follow this expiry within the per-tick limit
	assign more      = (count_q > CW'(1)) && (n_q < N_LIMIT);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		head_d      = head_q;
		n_d         = n_q;
		chk_d       = chk_s1;
		wpend_d     = wpend_s1;
		rem_d       = rem_q;
		new_tag_d   = new_tag_q;
		pos_d       = pos_q;
		split_d     = split_q;
		split_tag_d = split_tag_q;
		walk_d      = walk_q;
		chk_idx_d   = chk_idx_s1;
		shift_src_d = shift_src_q;
		wdst_d      = wdst_s1;
		pend_tag_d  = pend_tag_q;
		kind_d      = kind_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = head_q;
		ram_wr_data = '0;
		rsp_load    = 1'b0;
		rsp_d       = rsp_item_q;
		walk_done   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_item.opcode == dltq_pkg::OP_TICK) begin
						n_d = '0;
						if (count_q == '0) begin
							kind_d  = dltq_pkg::KIND_IDLE;
							state_d = ST_ONE;
						end else begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = head_q;
							state_d     = ST_TFRST;
						end
					end else begin
						rem_d     = req_item.delay;
						new_tag_d = req_item.event_tag;
						if (count_q == DEPTH_C) begin
							kind_d  = dltq_pkg::KIND_FULL;
							state_d = ST_ONE;
						end else if (count_q == '0) begin
							pos_d       = '0;
							shift_src_d = '0;
							wpend_d     = 1'b0;
							state_d     = ST_SHIFT;
						end else begin
							walk_d  = '0;
							chk_d   = 1'b0;
							state_d = ST_WALK;
						end
					end
				end
			end

			ST_WALK: begin
				// check the entry read last cycle, keep one read in flight
				if (chk_s1) begin
					if (rem_q < rd_delta) begin
						pos_d       = chk_idx_s1;
						split_d     = rd_delta - rem_q;
						split_tag_d = rd_tag;
						walk_done   = 1'b1;
					end else begin
						rem_d = rem_q - rd_delta;
						if (chk_idx_s1 + CW'(1) == count_q) begin
							pos_d     = count_q;
							walk_done = 1'b1;
						end
					end
				end
				if (walk_done) begin
					chk_d       = 1'b0;
					wpend_d     = 1'b0;
					shift_src_d = count_q;
					state_d     = ST_SHIFT;
				end else if (walk_q < count_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = phys(head_q, walk_q);
					walk_d      = walk_q + CW'(1);
					chk_d       = 1'b1;
					chk_idx_d   = walk_q;
				end else begin
					chk_d = 1'b0;
				end
			end

			ST_SHIFT: begin
				// move entry j-1 to j, from the tail down to pos+2
				if (wpend_s1) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = phys(head_q, wdst_s1);
					ram_wr_data = ram_rd_data;
				end
				if (shift_src_q > pos_q + CW'(1)) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = phys(head_q, shift_src_q - CW'(1));
					wpend_d     = 1'b1;
					wdst_d      = shift_src_q;
					shift_src_d = shift_src_q - CW'(1);
				end else begin
					wpend_d = 1'b0;
					if (!wpend_s1) begin
						state_d = (pos_q < count_q) ? ST_FIX : ST_PUT;
					end
				end
			end

			ST_FIX: begin
				// old entry at pos lands at pos+1 with its delta split
				ram_wr_en   = 1'b1;
				ram_wr_addr = phys(head_q, pos_q + CW'(1));
				ram_wr_data = {split_q, split_tag_q};
				state_d     = ST_PUT;
			end

			ST_PUT: begin
				if (out_free) begin
					ram_wr_en         = 1'b1;
					ram_wr_addr       = phys(head_q, pos_q);
					ram_wr_data       = {rem_q, new_tag_q};
					count_d           = count_q + CW'(1);
					rsp_load          = 1'b1;
					rsp_d.kind        = dltq_pkg::KIND_INSERTED;
					rsp_d.expired_tag = '0;
					rsp_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end

			ST_ONE: begin
				if (out_free) begin
					rsp_load          = 1'b1;
					rsp_d.kind        = kind_q;
					rsp_d.expired_tag = '0;
					rsp_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end

			ST_TFRST: begin
				// decrement the head; a zero or one delta expires
				if (rd_delta > DW'(1)) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = head_q;
					ram_wr_data = {rd_delta - DW'(1), rd_tag};
					kind_d      = dltq_pkg::KIND_IDLE;
					state_d     = ST_ONE;
				end else begin
					pend_tag_d = rd_tag;
					head_d     = head_inc;
					count_d    = count_q - CW'(1);
					n_d        = n_q + NW'(1);
					if (more) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = phys(head_q, CW'(1));
						state_d     = ST_TNEXT;
					end else begin
						state_d = ST_TLAST;
					end
				end
			end

			ST_TNEXT: begin
				// pending expiry is not last only if this head is due too
				if (rd_delta != '0) begin
					state_d = ST_TLAST;
				end else if (out_free) begin
					rsp_load          = 1'b1;
					rsp_d.kind        = dltq_pkg::KIND_EXPIRED;
					rsp_d.expired_tag = pend_tag_q;
					rsp_d.last        = 1'b0;
					pend_tag_d        = rd_tag;
					head_d            = head_inc;
					count_d           = count_q - CW'(1);
					n_d               = n_q + NW'(1);
					if (more) begin
						ram_rd_en   = 1'b1;
						ram_rd_addr = phys(head_q, CW'(1));
					end else begin
						state_d = ST_TLAST;
					end
				end
			end

			ST_TLAST: begin
				if (out_free) begin
					rsp_load          = 1'b1;
					rsp_d.kind        = dltq_pkg::KIND_EXPIRED;
					rsp_d.expired_tag = pend_tag_q;
					rsp_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			n_q         <= '0;
			chk_s1      <= 1'b0;
			wpend_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			head_q   <= head_d;
			n_q      <= n_d;
			chk_s1   <= chk_d;
			wpend_s1 <= wpend_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_q       <= rem_d;
		new_tag_q   <= new_tag_d;
		pos_q       <= pos_d;
		split_q     <= split_d;
		split_tag_q <= split_tag_d;
		walk_q      <= walk_d;
		chk_idx_s1  <= chk_idx_d;
		shift_src_q <= shift_src_d;
		wdst_s1     <= wdst_d;
		pend_tag_q  <= pend_tag_d;
		kind_q      <= kind_d;
		if (rsp_load) begin
			rsp_item_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// Fill count never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above queue depth");

	// The count grows only when an insert writes its entry.
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > $past(count_q)) |-> ($past(state_q) == ST_PUT))
		else $error("entry count grew outside insert");

	// A walk read in flight belongs to the walk.
	a_walk_read: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> (state_q == ST_WALK))
		else $error("walk read pending outside walk");

	// A pending shift write belongs to the shift.
	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		wpend_s1 |-> (state_q == ST_SHIFT))
		else $error("shift write pending outside shift");

endmodule
